>>> rtl/vtbb_pkg.sv
// ----------------------------------------------------------------------------
// vtbb_pkg
// Shared widths, register indexes, pipeline control type and saturation
// helpers for the vertex transform and bounding box block.
// ----------------------------------------------------------------------------
package vtbb_pkg;

    // Coordinates are signed fixed point, coefficients signed Q2.14.
    localparam int COORD_W        = 32;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int ROW_W          = 3 * COEF_W;

    // One coefficient times one coordinate, and three of those summed.
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

    // Register indexes of the configuration port. The two spare indexes decode
    // to nothing.
    typedef enum logic [2:0] {
        CFG_COEF_X   = 3'd0,
        CFG_COEF_Y   = 3'd1,
        CFG_COEF_Z   = 3'd2,
        CFG_OFFSET_X = 3'd3,
        CFG_OFFSET_Y = 3'd4,
        CFG_OFFSET_Z = 3'd5,
        CFG_SPARE_6  = 3'd6,
        CFG_SPARE_7  = 3'd7
    } cfg_reg_t;

    // Load strobes for the two pipeline registers inside a dot-product row.
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } row_ctrl_t;

    // Saturating add of two coordinates.
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        logic signed [COORD_W-1:0] r;
        s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
        if (s[COORD_W] != s[COORD_W-1])
        begin
            r = s[COORD_W] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    // Round half up to the coordinate format, then saturate.
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] sh;
        logic [SUM_W-COORD_W:0]  top;
        logic signed [COORD_W-1:0] r;
        t   = acc + ROUND_HALF;
        sh  = t >>> COEF_FRAC_BITS;
        top = sh[SUM_W-1:COORD_W-1];
        if ((&top) || !(|top))
        begin
            r = sh[COORD_W-1:0];
        end
        else
        begin
            r = sh[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

endpackage

>>> rtl/vtbb_row.sv
// ----------------------------------------------------------------------------
// vtbb_row
// One result axis: three coefficient products registered, then summed,
// rounded and saturated into a registered coordinate.
// ----------------------------------------------------------------------------
module vtbb_row (
    input  logic                                  clk,
    input  vtbb_pkg::row_ctrl_t                   ctrl,
    input  logic [vtbb_pkg::ROW_W-1:0]            coef,
    input  logic signed [vtbb_pkg::COORD_W-1:0]   p_x,
    input  logic signed [vtbb_pkg::COORD_W-1:0]   p_y,
    input  logic signed [vtbb_pkg::COORD_W-1:0]   p_z,
    output logic signed [vtbb_pkg::COORD_W-1:0]   result
);

    logic signed [vtbb_pkg::COEF_W-1:0] c_x;
    logic signed [vtbb_pkg::COEF_W-1:0] c_y;
    logic signed [vtbb_pkg::COEF_W-1:0] c_z;

    logic signed [vtbb_pkg::PROD_W-1:0] prod_x_reg;
    logic signed [vtbb_pkg::PROD_W-1:0] prod_y_reg;
    logic signed [vtbb_pkg::PROD_W-1:0] prod_z_reg;
    logic signed [vtbb_pkg::PROD_W-1:0] prod_x_next;
    logic signed [vtbb_pkg::PROD_W-1:0] prod_y_next;
    logic signed [vtbb_pkg::PROD_W-1:0] prod_z_next;

    logic signed [vtbb_pkg::SUM_W-1:0]   sum;
    logic signed [vtbb_pkg::COORD_W-1:0] result_reg;
    logic signed [vtbb_pkg::COORD_W-1:0] result_next;

    always_comb
    begin
        c_x = coef[vtbb_pkg::COEF_W-1:0];
        c_y = coef[2*vtbb_pkg::COEF_W-1:vtbb_pkg::COEF_W];
        c_z = coef[3*vtbb_pkg::COEF_W-1:2*vtbb_pkg::COEF_W];
        prod_x_next = vtbb_pkg::PROD_W'(c_x) * vtbb_pkg::PROD_W'(p_x);
        prod_y_next = vtbb_pkg::PROD_W'(c_y) * vtbb_pkg::PROD_W'(p_y);
        prod_z_next = vtbb_pkg::PROD_W'(c_z) * vtbb_pkg::PROD_W'(p_z);
        sum = vtbb_pkg::SUM_W'(prod_x_reg) + vtbb_pkg::SUM_W'(prod_y_reg)
            + vtbb_pkg::SUM_W'(prod_z_reg);
        result_next = vtbb_pkg::round_sat(sum);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
        if (ctrl.load_sum)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/vertex_transform_bounding_box.sv
// ----------------------------------------------------------------------------
// vertex_transform_bounding_box
// Translates and rotates one vertex per item and reports the transformed
// vertex together with the running axis-aligned bounding box.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ---------------------------------------
//  in       in_valid / in_ready    pos_x, pos_y, pos_z, start_pass
//  out      out_valid / out_ready  out_x..z, min_x..z, max_x..z
//  cfg      cfg_we (no wait)       cfg_index, cfg_data
//
// One item can enter every cycle unless a stalled output has filled the
// pipeline. An item passes five registers (input, offset add, products,
// sum and round, box update); its result is offered from the last of them.
// Each stage has its own valid bit and loads when it is empty or when its
// contents move on, so bubbles close up and up to five items wait behind a
// stalled output before the input stalls.
// Reset clears all valid bits, loads the identity matrix and zero offsets,
// and empties the box (minimum at the most positive value, maximum at the
// most negative value).
// ----------------------------------------------------------------------------
module vertex_transform_bounding_box (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [vtbb_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [vtbb_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [vtbb_pkg::COORD_W-1:0]   pos_z,
    input  logic                                  start_pass,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [vtbb_pkg::COORD_W-1:0]   out_x,
    output logic signed [vtbb_pkg::COORD_W-1:0]   out_y,
    output logic signed [vtbb_pkg::COORD_W-1:0]   out_z,
    output logic signed [vtbb_pkg::COORD_W-1:0]   min_x,
    output logic signed [vtbb_pkg::COORD_W-1:0]   min_y,
    output logic signed [vtbb_pkg::COORD_W-1:0]   min_z,
    output logic signed [vtbb_pkg::COORD_W-1:0]   max_x,
    output logic signed [vtbb_pkg::COORD_W-1:0]   max_y,
    output logic signed [vtbb_pkg::COORD_W-1:0]   max_z,

    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [vtbb_pkg::ROW_W-1:0]            cfg_data
);

    // Identity rows: 1.0 in Q2.14 placed in the x, y and z slot.
    localparam logic [vtbb_pkg::ROW_W-1:0] COEF_ONE =
        vtbb_pkg::ROW_W'(1) << vtbb_pkg::COEF_FRAC_BITS;

    localparam int CW = vtbb_pkg::COORD_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [vtbb_pkg::ROW_W-1:0] coef_x_reg;
    logic [vtbb_pkg::ROW_W-1:0] coef_y_reg;
    logic [vtbb_pkg::ROW_W-1:0] coef_z_reg;
    logic signed [CW-1:0]       offset_x_reg;
    logic signed [CW-1:0]       offset_y_reg;
    logic signed [CW-1:0]       offset_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg   <= COEF_ONE;
            coef_y_reg   <= COEF_ONE << vtbb_pkg::COEF_W;
            coef_z_reg   <= COEF_ONE << (2 * vtbb_pkg::COEF_W);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vtbb_pkg::CFG_COEF_X:   coef_x_reg   <= cfg_data;
                vtbb_pkg::CFG_COEF_Y:   coef_y_reg   <= cfg_data;
                vtbb_pkg::CFG_COEF_Z:   coef_z_reg   <= cfg_data;
                vtbb_pkg::CFG_OFFSET_X: offset_x_reg <= cfg_data[CW-1:0];
                vtbb_pkg::CFG_OFFSET_Y: offset_y_reg <= cfg_data[CW-1:0];
                vtbb_pkg::CFG_OFFSET_Z: offset_z_reg <= cfg_data[CW-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when the stage before it holds
    // an item and it is either empty or handing its own item on.
    // ------------------------------------------------------------------
    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;
    logic s0_vld_next, s1_vld_next, s2_vld_next, s3_vld_next, out_vld_next;
    logic in_accept, s1_load, s2_load, s3_load, out_load;
    vtbb_pkg::row_ctrl_t row_ctrl;

    always_comb
    begin
        out_load  = s3_vld_reg && (!out_vld_reg || out_ready);
        s3_load   = s2_vld_reg && (!s3_vld_reg || out_load);
        s2_load   = s1_vld_reg && (!s2_vld_reg || s3_load);
        s1_load   = s0_vld_reg && (!s1_vld_reg || s2_load);
        in_ready  = !s0_vld_reg || s1_load;
        in_accept = in_valid && in_ready;

        s0_vld_next  = in_accept || (s0_vld_reg && !s1_load);
        s1_vld_next  = s1_load   || (s1_vld_reg && !s2_load);
        s2_vld_next  = s2_load   || (s2_vld_reg && !s3_load);
        s3_vld_next  = s3_load   || (s3_vld_reg && !out_load);
        out_vld_next = out_load  || (out_vld_reg && !out_ready);

        row_ctrl.load_prod = s2_load;
        row_ctrl.load_sum  = s3_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg  <= s0_vld_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            s3_vld_reg  <= s3_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register, then the saturating translation.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] s0_x_reg, s0_y_reg, s0_z_reg;
    logic signed [CW-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [CW-1:0] s1_x_next, s1_y_next, s1_z_next;
    logic s0_start_reg, s1_start_reg, s2_start_reg, s3_start_reg;

    always_comb
    begin
        s1_x_next = vtbb_pkg::sat_add(s0_x_reg, offset_x_reg);
        s1_y_next = vtbb_pkg::sat_add(s0_y_reg, offset_y_reg);
        s1_z_next = vtbb_pkg::sat_add(s0_z_reg, offset_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_x_reg     <= pos_x;
            s0_y_reg     <= pos_y;
            s0_z_reg     <= pos_z;
            s0_start_reg <= start_pass;
        end
        if (s1_load)
        begin
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_z_reg     <= s1_z_next;
            s1_start_reg <= s0_start_reg;
        end
        // The start flag travels alongside the rows' product and sum stages.
        if (s2_load)
        begin
            s2_start_reg <= s1_start_reg;
        end
        if (s3_load)
        begin
            s3_start_reg <= s2_start_reg;
        end
    end

    // ------------------------------------------------------------------
    // Rotation: one dot-product row per result axis.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_x, r_y, r_z;

    vtbb_row u_row_x (
        .clk    (clk),
        .ctrl   (row_ctrl),
        .coef   (coef_x_reg),
        .p_x    (s1_x_reg),
        .p_y    (s1_y_reg),
        .p_z    (s1_z_reg),
        .result (r_x)
    );

    vtbb_row u_row_y (
        .clk    (clk),
        .ctrl   (row_ctrl),
        .coef   (coef_y_reg),
        .p_x    (s1_x_reg),
        .p_y    (s1_y_reg),
        .p_z    (s1_z_reg),
        .result (r_y)
    );

    vtbb_row u_row_z (
        .clk    (clk),
        .ctrl   (row_ctrl),
        .coef   (coef_z_reg),
        .p_x    (s1_x_reg),
        .p_y    (s1_y_reg),
        .p_z    (s1_z_reg),
        .result (r_z)
    );

    // ------------------------------------------------------------------
    // Bounding box. The box registers double as the result's min and max
    // fields: they only change when a new result is loaded, so they always
    // match the vertex held in the output register.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [CW-1:0] box_low_x_reg, box_low_y_reg, box_low_z_reg;
    logic signed [CW-1:0] box_high_x_reg, box_high_y_reg, box_high_z_reg;
    logic signed [CW-1:0] box_low_x_next, box_low_y_next, box_low_z_next;
    logic signed [CW-1:0] box_high_x_next, box_high_y_next, box_high_z_next;
    logic signed [CW-1:0] low_x, low_y, low_z, high_x, high_y, high_z;

    always_comb
    begin
        // A start of pass empties the box before this vertex is counted.
        low_x  = s3_start_reg ? vtbb_pkg::COORD_MAX : box_low_x_reg;
        low_y  = s3_start_reg ? vtbb_pkg::COORD_MAX : box_low_y_reg;
        low_z  = s3_start_reg ? vtbb_pkg::COORD_MAX : box_low_z_reg;
        high_x = s3_start_reg ? vtbb_pkg::COORD_MIN : box_high_x_reg;
        high_y = s3_start_reg ? vtbb_pkg::COORD_MIN : box_high_y_reg;
        high_z = s3_start_reg ? vtbb_pkg::COORD_MIN : box_high_z_reg;

        box_low_x_next  = (r_x < low_x)  ? r_x : low_x;
        box_low_y_next  = (r_y < low_y)  ? r_y : low_y;
        box_low_z_next  = (r_z < low_z)  ? r_z : low_z;
        box_high_x_next = (r_x > high_x) ? r_x : high_x;
        box_high_y_next = (r_y > high_y) ? r_y : high_y;
        box_high_z_next = (r_z > high_z) ? r_z : high_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_low_x_reg  <= vtbb_pkg::COORD_MAX;
            box_low_y_reg  <= vtbb_pkg::COORD_MAX;
            box_low_z_reg  <= vtbb_pkg::COORD_MAX;
            box_high_x_reg <= vtbb_pkg::COORD_MIN;
            box_high_y_reg <= vtbb_pkg::COORD_MIN;
            box_high_z_reg <= vtbb_pkg::COORD_MIN;
        end
        else if (out_load)
        begin
            box_low_x_reg  <= box_low_x_next;
            box_low_y_reg  <= box_low_y_next;
            box_low_z_reg  <= box_low_z_next;
            box_high_x_reg <= box_high_x_next;
            box_high_y_reg <= box_high_y_next;
            box_high_z_reg <= box_high_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg <= r_x;
            out_y_reg <= r_y;
            out_z_reg <= r_z;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign min_x     = box_low_x_reg;
    assign min_y     = box_low_y_reg;
    assign min_z     = box_low_z_reg;
    assign max_x     = box_high_x_reg;
    assign max_y     = box_high_y_reg;
    assign max_z     = box_high_z_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every shown result lies inside the box shown with it.
    a_vertex_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_x <= out_x) && (out_x <= max_x)
                   && (min_y <= out_y) && (out_y <= max_y)
                   && (min_z <= out_z) && (out_z <= max_z))
        else $error("result vertex lies outside its bounding box");

    // A vertex that starts a pass leaves a box of that single point.
    a_start_single_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s3_start_reg) |=> (min_x == out_x) && (max_x == out_x)
                                     && (min_y == out_y) && (max_y == out_y)
                                     && (min_z == out_z) && (max_z == out_z))
        else $error("start of pass did not reset the bounding box");

    // An empty input register always takes an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s0_vld_reg |-> in_ready)
        else $error("input stalled with an empty input register");

    // An item in the product stage is never dropped while it waits.
    a_hold_products: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && !s3_load) |=> s2_vld_reg)
        else $error("item lost in the product stage");

    // The box only moves when a new result is loaded.
    a_box_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(min_x) && $stable(max_x) && $stable(min_y)
                   && $stable(max_y) && $stable(min_z) && $stable(max_z))
        else $error("bounding box changed without a new result");

endmodule
